### src/lpd_pkg.sv
// Shared types and codes for the length-prefixed deframer.
`default_nettype none
package lpd_pkg;

  localparam logic [1:0] EV_PAYLOAD   = 2'd0;
  localparam logic [1:0] EV_EMPTY     = 2'd1;
  localparam logic [1:0] EV_LEN_ERROR = 2'd2;

  localparam logic [1:0] FMT_UNDETECTED = 2'd0;
  localparam logic [1:0] FMT_LEGACY     = 2'd1;
  localparam logic [1:0] FMT_TYPED      = 2'd2;

  localparam logic [1:0] ROUTE_LEGACY = 2'd0;
  localparam logic [1:0] ROUTE_VIDEO  = 2'd1;
  localparam logic [1:0] ROUTE_AUDIO  = 2'd2;
  localparam logic [1:0] ROUTE_DROP   = 2'd3;

  localparam logic [7:0] TYPE_VIDEO = 8'h01;
  localparam logic [7:0] TYPE_AUDIO = 8'h02;

  // Index of the last of the four length bytes.
  localparam logic [1:0] HDR_LAST = 2'd3;

  localparam logic       CMD_BYTE    = 1'b0;
  localparam logic       CMD_CONNECT = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } lpd_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [1:0] stream_kind;
    logic [7:0] payload_byte;
    logic       frame_first;
    logic       frame_last;
  } lpd_result_t;

endpackage : lpd_pkg
`default_nettype wire

### src/lpd_front.sv
// Front end: header parsing, format detection and routing of each stream item.
`default_nettype none
module lpd_front import lpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire lpd_item_t   item,
  input  wire logic [31:0] max_len,
  output logic             res_valid,
  output lpd_result_t      res
);

  logic        in_body_r, in_body_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] len_shift_r, len_shift_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [1:0]  route_r, route_nxt;
  logic        at_start_r, at_start_nxt;
  logic        type_seen_r, type_seen_nxt;

  logic [31:0] shifted;
  logic        last;
  logic [1:0]  fmt_now;

  always_comb begin
    in_body_nxt   = in_body_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    len_shift_nxt = len_shift_r;
    remaining_nxt = remaining_r;
    fmt_nxt       = fmt_r;
    route_nxt     = route_r;
    at_start_nxt  = at_start_r;
    type_seen_nxt = type_seen_r;
    res_valid     = 1'b0;
    res           = '0;
    shifted       = {len_shift_r[23:0], item.data_byte};
    last          = (remaining_r == 32'd1);
    fmt_now       = fmt_r;

    if (item.command == CMD_CONNECT) begin
      in_body_nxt   = 1'b0;
      hdr_cnt_nxt   = '0;
      len_shift_nxt = '0;
      remaining_nxt = '0;
      fmt_nxt       = FMT_UNDETECTED;
      route_nxt     = ROUTE_LEGACY;
      at_start_nxt  = 1'b1;
      type_seen_nxt = 1'b0;
    end else if (!in_body_r) begin
      hdr_cnt_nxt   = hdr_cnt_r + 2'd1;
      len_shift_nxt = shifted;
      if (hdr_cnt_r == HDR_LAST) begin
        len_shift_nxt = '0;
        if (shifted > max_len) begin
          res_valid       = 1'b1;
          res.event_kind  = EV_LEN_ERROR;
          res.frame_first = 1'b1;
          res.frame_last  = 1'b1;
        end else if (shifted == 32'd0) begin
          res_valid       = 1'b1;
          res.event_kind  = EV_EMPTY;
          res.frame_first = 1'b1;
          res.frame_last  = 1'b1;
        end else begin
          in_body_nxt   = 1'b1;
          remaining_nxt = shifted;
          at_start_nxt  = 1'b1;
          route_nxt     = ROUTE_LEGACY;
          type_seen_nxt = 1'b0;
        end
      end
    end else begin
      remaining_nxt = remaining_r - 32'd1;
      type_seen_nxt = 1'b0;
      if (last) begin
        in_body_nxt = 1'b0;
      end
      if (at_start_r) begin
        at_start_nxt = 1'b0;
        route_nxt    = ROUTE_LEGACY;
        // At the body start the remaining count still equals the body length.
        if (remaining_r > 32'd1) begin
          if (fmt_r == FMT_UNDETECTED) begin
            fmt_now = (item.data_byte == TYPE_VIDEO || item.data_byte == TYPE_AUDIO) ?
                      FMT_TYPED : FMT_LEGACY;
          end
          fmt_nxt = fmt_now;
          if (fmt_now == FMT_TYPED) begin
            type_seen_nxt = 1'b1;
            if (item.data_byte == TYPE_VIDEO) begin
              route_nxt = ROUTE_VIDEO;
            end else if (item.data_byte == TYPE_AUDIO) begin
              route_nxt = ROUTE_AUDIO;
            end else begin
              route_nxt = ROUTE_DROP;
            end
          end
        end
      end
      // The type byte itself and every byte of a dropped frame give no item.
      if (!type_seen_nxt && route_nxt != ROUTE_DROP) begin
        res_valid        = 1'b1;
        res.event_kind   = EV_PAYLOAD;
        res.stream_kind  = route_nxt;
        res.payload_byte = item.data_byte;
        res.frame_first  = (route_nxt == ROUTE_LEGACY) ? at_start_r : type_seen_r;
        res.frame_last   = last;
      end
    end

    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r   <= 1'b0;
      hdr_cnt_r   <= '0;
      len_shift_r <= '0;
      remaining_r <= '0;
      fmt_r       <= FMT_UNDETECTED;
      route_r     <= ROUTE_LEGACY;
      at_start_r  <= 1'b1;
      type_seen_r <= 1'b0;
    end else if (accept) begin
      in_body_r   <= in_body_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      len_shift_r <= len_shift_nxt;
      remaining_r <= remaining_nxt;
      fmt_r       <= fmt_nxt;
      route_r     <= route_nxt;
      at_start_r  <= at_start_nxt;
      type_seen_r <= type_seen_nxt;
    end
  end

endmodule : lpd_front
`default_nettype wire

### src/lpd_fifo.sv
// Short result queue between the front end and the output stage.
`default_nettype none
module lpd_fifo import lpd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire lpd_result_t push_data,
  input  wire logic        pop,
  output logic             not_empty,
  output logic             not_full,
  output lpd_result_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpd_result_t        mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule : lpd_fifo
`default_nettype wire

### src/lpd_back.sv
// Output stage: registers queued results and presents them on the result channel.
`default_nettype none
module lpd_back import lpd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire lpd_result_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output lpd_result_t      out_data
);

  logic        valid_r;
  lpd_result_t data_r;

  assign q_pop     = q_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_data;
    end
  end

endmodule : lpd_back
`default_nettype wire

### src/length_prefixed_deframer_core.sv
// Top level of the length-prefixed deframer: front end, result queue and output stage.
`default_nettype none
// The block splits a byte stream into frames, each a 4-byte big-endian body length
// followed by that many body bytes, and passes each body byte on as one result item
// with first and last marks and a stream kind (legacy video, video or audio). A
// length above cfg max_frame_length gives one length-error item and header parsing
// restarts at the next byte; a zero length gives one empty-frame item. The first
// body of two or more bytes after a new-connection item fixes the format: a first
// byte of 1 or 2 selects the type-byte format, where that byte routes the frame and
// is not passed on (other values drop the frame); otherwise bodies pass as legacy
// video. Throughput is one item per clock while the result queue has room: the
// front end parses each byte with four 32-bit compares and one 32-bit decrement,
// and the result queue of QUEUE_DEPTH entries (at least 2) plus the registered
// output stage keep the input flowing while a result waits to be taken, until
// the queue fills. A result is written into the queue as its item is accepted and
// is then registered into the output stage when that stage is empty or being read.
// The configuration register is written with cfg_wr_en and may change only while
// the block is idle.
module length_prefixed_deframer_core import lpd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [1:0]       out_stream_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_frame_first,
  output logic             out_frame_last
);

  // Largest accepted body length; the reset value is 8 MiB.
  logic [31:0] max_len_r;

  lpd_item_t   item;
  logic        accept;
  logic        res_valid;
  lpd_result_t res;
  logic        q_not_empty, q_not_full, q_pop;
  lpd_result_t q_head;
  lpd_result_t out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 32'd8388608;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // An item is taken whenever the queue has room, whether or not it yields a result.
  assign in_ready       = q_not_full;
  assign accept         = in_valid && in_ready;
  assign item.command   = in_command;
  assign item.data_byte = in_data_byte;

  lpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .not_full  (q_not_full),
    .head      (q_head)
  );

  lpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_event_kind   = out_data.event_kind;
  assign out_stream_kind  = out_data.stream_kind;
  assign out_payload_byte = out_data.payload_byte;
  assign out_frame_first  = out_data.frame_first;
  assign out_frame_last   = out_data.frame_last;

endmodule : length_prefixed_deframer_core
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the length-prefixed deframer core.
`timescale 1ns / 100ps

module tb_top;
  import lpd_pkg::*;

  // Drain time after the last expected result: the output register, the result
  // queue and some margin for items that produce nothing.
  localparam int SETTLE_CYCLES = 8;
  // Length of the long receiver hold-off used to fill the block up.
  localparam int HOLD_CYCLES = 200;
  // Number of failures that are reported in detail.
  localparam int REPORT_LIMIT = 10;
  localparam logic [31:0] RESET_MAX_LENGTH = 32'd8388608;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_BYTE;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_kind;
  logic [1:0]  out_stream_kind;
  logic [7:0]  out_payload_byte;
  logic        out_frame_first;
  logic        out_frame_last;

  length_prefixed_deframer_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_stream_kind  (out_stream_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_first  (out_frame_first),
    .out_frame_last   (out_frame_last)
  );

  // Results the deframer owes us, oldest first.
  lpd_result_t pending_results[$];
  int          fail_count = 0;
  int          items_sent = 0;

  // Percent chance per item (sender) or per cycle (receiver) that a burst of
  // idle cycles starts. Zero gives stretches with no idling at all.
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  // The pressure test raises hold_request; the hold-off process answers by
  // keeping hold_active high for the long hold-off.
  bit          hold_request = 1'b0;
  logic        hold_active = 1'b0;

  // Our own copy of the parser state and of the one configuration register.
  logic        parse_in_body;
  logic [1:0]  parse_hdr_count;
  logic [31:0] parse_len_shift;
  logic [31:0] parse_remaining;
  logic [31:0] parse_frame_len;
  logic [1:0]  parse_format;
  logic [1:0]  parse_route;
  logic        parse_body_start;
  logic [31:0] max_length_reg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Last-resort guard: a hung handshake or a missing result ends up here.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Counts a failure and prints the first few in detail.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Puts the parser back to the start of a header. The format is kept; only
  // a new connection forgets it.
  task automatic clear_parser();
    parse_in_body    = 1'b0;
    parse_hdr_count  = '0;
    parse_len_shift  = '0;
    parse_remaining  = '0;
    parse_frame_len  = '0;
    parse_route      = ROUTE_LEGACY;
    parse_body_start = 1'b1;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [1:0] stream,
                             input logic [7:0] data, input logic first,
                             input logic last);
    lpd_result_t r;
    r.event_kind   = kind;
    r.stream_kind  = stream;
    r.payload_byte = data;
    r.frame_first  = first;
    r.frame_last   = last;
    pending_results.push_back(r);
  endtask

  // Advances the deframer state by one accepted item and queues the result
  // that item should produce, if any.
  task automatic deframe_predict(input logic cmd, input logic [7:0] b);
    logic [31:0] pos;
    logic        last;
    logic        first;
    if (cmd == CMD_CONNECT) begin
      parse_format = FMT_UNDETECTED;
      clear_parser();
      return;
    end

    if (!parse_in_body) begin
      // Length bytes arrive most significant first.
      parse_len_shift = {parse_len_shift[23:0], b};
      if (parse_hdr_count != HDR_LAST) begin
        parse_hdr_count++;
        return;
      end
      parse_hdr_count = '0;
      parse_frame_len = parse_len_shift;
      parse_len_shift = '0;
      if (parse_frame_len > max_length_reg) begin
        parse_frame_len = '0;
        push_result(EV_LEN_ERROR, ROUTE_LEGACY, 8'h00, 1'b1, 1'b1);
        return;
      end
      if (parse_frame_len == '0) begin
        push_result(EV_EMPTY, ROUTE_LEGACY, 8'h00, 1'b1, 1'b1);
        return;
      end
      parse_in_body    = 1'b1;
      parse_remaining  = parse_frame_len;
      parse_body_start = 1'b1;
      parse_route      = ROUTE_LEGACY;
      return;
    end

    pos = parse_frame_len - parse_remaining;
    parse_remaining = parse_remaining - 32'd1;
    last = (parse_remaining == '0);
    if (last) begin
      parse_in_body   = 1'b0;
      parse_hdr_count = '0;
      parse_len_shift = '0;
    end

    if (parse_body_start) begin
      parse_body_start = 1'b0;
      parse_route = ROUTE_LEGACY;
      // Only bodies of two or more bytes can fix the format or carry a type.
      if (parse_frame_len > 32'd1) begin
        if (parse_format == FMT_UNDETECTED) begin
          parse_format = (b == TYPE_VIDEO || b == TYPE_AUDIO) ? FMT_TYPED : FMT_LEGACY;
        end
        if (parse_format == FMT_TYPED) begin
          if (b == TYPE_VIDEO) begin
            parse_route = ROUTE_VIDEO;
          end else if (b == TYPE_AUDIO) begin
            parse_route = ROUTE_AUDIO;
          end else begin
            parse_route = ROUTE_DROP;
          end
          // The type byte itself is swallowed.
          return;
        end
      end
    end

    if (parse_route == ROUTE_DROP) begin
      return;
    end
    // A routed frame starts its output one byte in, after the type byte.
    first = (parse_route == ROUTE_LEGACY) ? (pos == 32'd0) : (pos == 32'd1);
    push_result(EV_PAYLOAD, parse_route, b, first, last);
  endtask

  // Offers one item and waits until the deframer takes it. Called at a rising
  // edge. When no idle burst is drawn, valid simply stays high and only the
  // payload changes, so valid is never dropped and raised in the same step.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= b;
    // Signals read right after the edge still hold their pre-edge values.
    do @(posedge clk); while (!in_ready);
    items_sent++;
    deframe_predict(cmd, b);
  endtask

  task automatic send_connect();
    send_item(CMD_CONNECT, 8'($urandom));
  endtask

  // Sends a 4-byte big-endian length header.
  task automatic send_length(input logic [31:0] len);
    send_item(CMD_BYTE, len[31:24]);
    send_item(CMD_BYTE, len[23:16]);
    send_item(CMD_BYTE, len[15:8]);
    send_item(CMD_BYTE, len[7:0]);
  endtask

  // Lowers valid and waits until every result has come out, then lets the
  // pipeline run dry so that a register write finds the block idle.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_length_reg = value;
  endtask

  // Result checker and receiver. Acceptance is judged on the values seen at
  // the edge; the next ready level is then chosen, either from a random stall
  // burst or from the long hold-off.
  initial begin
    int          stall_left;
    lpd_result_t got;
    lpd_result_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.event_kind   = out_event_kind;
        got.stream_kind  = out_stream_kind;
        got.payload_byte = out_payload_byte;
        got.frame_first  = out_frame_first;
        got.frame_last   = out_frame_last;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result kind=%0d stream=%0d byte=%02h f=%0b l=%0b",
                                 got.event_kind, got.stream_kind, got.payload_byte,
                                 got.frame_first, got.frame_last));
        end else begin
          want = pending_results.pop_front();
          if (got.event_kind !== want.event_kind || got.stream_kind !== want.stream_kind ||
              got.payload_byte !== want.payload_byte ||
              got.frame_first !== want.frame_first || got.frame_last !== want.frame_last) begin
            note_failure($sformatf({"mismatch: expected kind=%0d stream=%0d byte=%02h f=%0b ",
                                    "l=%0b, got kind=%0d stream=%0d byte=%02h f=%0b l=%0b"},
                                   want.event_kind, want.stream_kind, want.payload_byte,
                                   want.frame_first, want.frame_last,
                                   got.event_kind, got.stream_kind, got.payload_byte,
                                   got.frame_first, got.frame_last));
          end
        end
      end
      if (hold_active) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (receiver_stall_pct != 0 && $urandom_range(0, 99) < receiver_stall_pct) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps running freely.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
        hold_request = 1'b0;
      end
    end
  end

  // Empty frames and length errors at the default limit. Neither of them
  // fixes the format, so the stream is still undetected afterwards.
  task automatic test_framing_events();
    send_length(32'h0000_0000);
    send_length(32'hFFFF_FFFF);
    settle_block();
  endtask

  // The first long body starts with 1, so the connection is type-byte: video,
  // a one-byte body that passes as legacy, audio, and a dropped frame.
  task automatic test_type_routing();
    send_length(32'd2);
    send_item(CMD_BYTE, TYPE_VIDEO);
    send_item(CMD_BYTE, 8'hFF);
    send_length(32'd1);
    send_item(CMD_BYTE, TYPE_AUDIO);
    send_length(32'd2);
    send_item(CMD_BYTE, TYPE_AUDIO);
    send_item(CMD_BYTE, 8'h00);
    send_length(32'd2);
    send_item(CMD_BYTE, 8'h07);
    send_item(CMD_BYTE, 8'h33);
    settle_block();
  endtask

  // A new connection forgets the format; a first byte other than 1 or 2
  // makes it legacy, and the whole body passes as legacy video.
  task automatic test_legacy_format();
    send_connect();
    send_length(32'd2);
    send_item(CMD_BYTE, 8'h80);
    send_item(CMD_BYTE, 8'h7F);
    settle_block();
  endtask

  // The receiver stops for a long stretch while a long legacy frame keeps
  // coming, so the result queue fills and the input has to stall.
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_connect();
    hold_request = 1'b1;
    send_length(32'd64);
    send_item(CMD_BYTE, 8'h10);
    repeat (63) send_item(CMD_BYTE, 8'($urandom));
    settle_block();
  endtask

  // One random frame, mostly well formed, sometimes broken or interrupted.
  task automatic send_random_frame();
    int          pick;
    int          cut;
    logic [31:0] len;
    logic [31:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_connect();
    end else if (pick < 8) begin
      // Stray bytes knock the header out of step; a reconnect often follows.
      repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, 8'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        send_connect();
      end
    end else if (pick < 14) begin
      if (max_length_reg == 32'hFFFF_FFFF) begin
        // Nothing is too long here: start a huge body and abandon it.
        send_length(32'hFFFF_FFFF);
        repeat ($urandom_range(0, 3)) send_item(CMD_BYTE, 8'($urandom));
        send_connect();
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          len = 32'hFFFF_FFFF;
        end else begin
          span = 32'hFFFF_FFFF - max_length_reg;
          len = max_length_reg + 32'd1 + ((span > 32'd3) ? 32'($urandom_range(0, 3)) : 32'd0);
        end
        send_length(len);
      end
    end else if (pick < 20) begin
      send_length(32'd0);
    end else begin
      if ($urandom_range(0, 19) == 0) begin
        len = $urandom_range(13, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      // Clipping to the limit also hits the exact-limit case.
      if (len > max_length_reg) begin
        len = max_length_reg;
      end
      send_length(len);
      if (len != 0) begin
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, int'(len) - 1) : int'(len);
        pick = $urandom_range(0, 9);
        if (cut > 0) begin
          if (pick < 4) begin
            send_item(CMD_BYTE, TYPE_VIDEO);
          end else if (pick < 7) begin
            send_item(CMD_BYTE, TYPE_AUDIO);
          end else begin
            send_item(CMD_BYTE, 8'($urandom));
          end
        end
        for (int i = 1; i < cut; i++) begin
          send_item(CMD_BYTE, 8'($urandom));
        end
        // A truncated body is cut short by a new connection.
        if (cut != int'(len)) begin
          send_connect();
        end
      end
    end
  endtask

  // One random phase: set the limit on an idle block, then send frames
  // until the item budget of the phase is spent.
  task automatic run_random_phase(input logic [31:0] limit, input int budget,
                                  input int idle_pct, input int stall_pct);
    int stop_at;
    settle_block();
    write_max_length(limit);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      send_random_frame();
    end
  endtask

  // Random traffic across several limits, the extremes among them. The last
  // phase runs with no idling on either side.
  task automatic test_random_traffic();
    run_random_phase(RESET_MAX_LENGTH, 110, 20, 20);
    run_random_phase(32'd16, 100, 0, 30);
    run_random_phase(32'd0, 30, 30, 10);
    run_random_phase(32'd1, 50, 15, 15);
    run_random_phase(32'hFFFF_FFFF, 100, 10, 25);
    run_random_phase(32'd24, 110, 0, 0);
  endtask

  initial begin
    int wait_count;
    max_length_reg = RESET_MAX_LENGTH;
    parse_format = FMT_UNDETECTED;
    clear_parser();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_framing_events();
    test_type_routing();
    test_legacy_format();
    test_output_backpressure();
    test_random_traffic();

    // Let everything still owed come out, with a bound on the wait.
    in_valid <= 1'b0;
    wait_count = 0;
    while (pending_results.size() != 0 && wait_count < 5000) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (20) @(posedge clk);
    while (pending_results.size() != 0) begin
      void'(pending_results.pop_front());
      note_failure("expected result never arrived");
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
